### hw/rtl/layered_pixel_compositor_macros.svh
// assertion helpers for the layered pixel compositor
// every assertion samples on clock and is off while reset is high
`ifndef LAYERED_PIXEL_COMPOSITOR_MACROS_SVH
`define LAYERED_PIXEL_COMPOSITOR_MACROS_SVH

// property that must hold in the same cycle
`define LPC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// property that must hold in the cycle after a trigger
`define LPC_ASSERT_NEXT(label, trig, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (prop)) \
      else $error(msg);

`endif

### hw/rtl/lpc_pkg.sv
package lpc_pkg;

   // screen geometry
   localparam int SCREEN_WIDTH  = 1024;
   localparam int SCREEN_HEIGHT = 768;
   localparam int CURSOR_SIZE   = 16;

   // signed coordinate wide enough for origin plus size of any rectangle
   localparam int COORD_W = 14;
   typedef logic signed [COORD_W-1:0] coord_type;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 12;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIN_X       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIN_Y       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIN_WIDTH   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIN_HEIGHT  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIN_PRESENT = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_CURSOR_X    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_CURSOR_Y    = 3'd6;

   localparam logic [9:0] CURSOR_X_RESET = 10'd512;
   localparam logic [9:0] CURSOR_Y_RESET = 10'd384;

   // layer numbers
   localparam logic [2:0] LAYER_GRADIENT = 3'd0;
   localparam logic [2:0] LAYER_PANEL    = 3'd1;
   localparam logic [2:0] LAYER_TEXTBOX  = 3'd2;
   localparam logic [2:0] LAYER_SHADOW   = 3'd3;
   localparam logic [2:0] LAYER_TITLE    = 3'd4;
   localparam logic [2:0] LAYER_CLOSE    = 3'd5;
   localparam logic [2:0] LAYER_CLIENT   = 3'd6;
   localparam logic [2:0] LAYER_CURSOR   = 3'd7;

   // colors
   localparam logic [7:0]  GRAD_ALPHA     = 8'hFF;
   localparam logic [7:0]  GRAD_RED       = 8'h2A;
   localparam logic [7:0]  GRAD_GREEN     = 8'h2D;
   localparam logic [7:0]  GRAD_BLUE_BASE = 8'h35;
   localparam logic [31:0] COLOR_PANEL    = 32'hFF15171C;
   localparam logic [31:0] COLOR_TEXTBOX  = 32'hFF21252B;
   localparam logic [31:0] COLOR_SHADOW   = 32'h55000000;
   localparam logic [31:0] COLOR_TITLE    = 32'hFF1E88E5;
   localparam logic [31:0] COLOR_CLOSE    = 32'hFFE53935;
   localparam logic [31:0] COLOR_WHITE    = 32'hFFFFFFFF;
   localparam logic [31:0] COLOR_BLUE     = 32'hFF1E88E5;

   // fixed rectangles and window offsets
   localparam coord_type PANEL_X    = 14'sd0;
   localparam coord_type PANEL_Y    = 14'sd0;
   localparam coord_type PANEL_W    = 14'sd1024;
   localparam coord_type PANEL_H    = 14'sd40;
   localparam coord_type TEXT_X     = 14'sd10;
   localparam coord_type TEXT_Y     = 14'sd8;
   localparam coord_type TEXT_W     = 14'sd480;
   localparam coord_type TEXT_H     = 14'sd24;
   localparam coord_type SHADOW_OFS = 14'sd8;
   localparam coord_type TITLE_H    = 14'sd24;
   localparam coord_type CLOSE_DX   = 14'sd5;
   localparam coord_type CLOSE_DY   = 14'sd18;
   localparam coord_type CLOSE_SIZE = 14'sd12;
   localparam coord_type CURSOR_SZ  = 14'sd16;

   // sprite masks, bit n of a row is sprite column n
   localparam logic [15:0] SPRITE_WHITE [CURSOR_SIZE] = '{
      16'b0000001111111111,
      16'b0000001000000001,
      16'b0000000100000001,
      16'b0000000010000001,
      16'b0000000100000001,
      16'b0000001000010001,
      16'b0000010000101001,
      16'b0000100001000101,
      16'b0001000010000011,
      16'b0001000100000001,
      16'b0001001000000000,
      16'b0001010000000000,
      16'b0001100000000000,
      16'b0000000000000000,
      16'b0000000000000000,
      16'b0000000000000000
   };
   localparam logic [15:0] SPRITE_BLUE [CURSOR_SIZE] = '{
      16'b0000000000000000,
      16'b0000000111111110,
      16'b0000000011111110,
      16'b0000000001111110,
      16'b0000000011111110,
      16'b0000000111101110,
      16'b0000001111000110,
      16'b0000011110000010,
      16'b0000111100000000,
      16'b0000111000000000,
      16'b0000110000000000,
      16'b0000100000000000,
      16'b0000000000000000,
      16'b0000000000000000,
      16'b0000000000000000,
      16'b0000000000000000
   };

   typedef struct packed {
      logic [9:0]  pixel_x;
      logic [9:0]  pixel_y;
      logic [31:0] client_pixel;
   } req_type;

   typedef struct packed {
      logic [31:0] pixel_color;
      logic [2:0]  layer;
   } rsp_type;

   // rectangle hit test, a negative origin draws nothing
   function automatic logic covers(input coord_type px, input coord_type py,
                                   input coord_type ox, input coord_type oy,
                                   input coord_type w, input coord_type h);
      logic hit;
      hit = !ox[COORD_W-1] && !oy[COORD_W-1] &&
            (px >= ox) && (px < ox + w) && (py >= oy) && (py < oy + h);
      return hit;
   endfunction

endpackage

### hw/rtl/layered_pixel_compositor.sv
// layered pixel compositor with a 16x16 hardware cursor. each transfer on the
// req channel carries one screen coordinate and the client buffer word for that
// place; one rsp transfer returns the final argb color and the number of the
// layer that won. layers, last one on top: blue gradient, top panel, text box,
// window shadow, title bar, close box, client pixel, cursor sprite. the window
// layers show only while win_present is set, and a rectangle whose origin is
// negative is not drawn. rate: one pixel per clock while rsp_stall is low; a
// pixel goes through the input register, then the result register, with the
// whole layer test done in a single pass between them. rsp_stall holds the
// result register and backs up into req_stall only once the input register is
// also full. csr writes always complete (csr_ready is tied high) and should
// only be issued while no pixel is in flight.
module layered_pixel_compositor (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  lpc_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output lpc_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lpc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [lpc_pkg::CSR_DATA_W-1:0]       csr_data
);
   import lpc_pkg::*;

   // configuration registers
   logic signed [11:0] win_x_ff, win_x_in;
   logic signed [11:0] win_y_ff, win_y_in;
   logic [11:0]        win_width_ff, win_width_in;
   logic [11:0]        win_height_ff, win_height_in;
   logic               win_present_ff, win_present_in;
   logic [9:0]         cursor_x_ff, cursor_x_in;
   logic [9:0]         cursor_y_ff, cursor_y_in;

   // pipeline registers
   logic    s1_valid_ff, s1_valid_in;
   req_type s1_data_ff, s1_data_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic    out_ready;
   logic    csr_write;

   // compose signals
   coord_type px, py, wx, wy, ww, wh, cx, cy;
   logic      on_screen;
   logic [7:0] grad_blue;
   logic [9:0] cur_dx, cur_dy;
   logic [31:0] color;
   logic [2:0]  layer;

   // ---------------------------------------------------------------------------
   // configuration port
   // ---------------------------------------------------------------------------
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      win_x_in       = win_x_ff;
      win_y_in       = win_y_ff;
      win_width_in   = win_width_ff;
      win_height_in  = win_height_ff;
      win_present_in = win_present_ff;
      cursor_x_in    = cursor_x_ff;
      cursor_y_in    = cursor_y_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_WIN_X:       win_x_in       = csr_data[11:0];
            CSR_WIN_Y:       win_y_in       = csr_data[11:0];
            CSR_WIN_WIDTH:   win_width_in   = csr_data[11:0];
            CSR_WIN_HEIGHT:  win_height_in  = csr_data[11:0];
            CSR_WIN_PRESENT: win_present_in = csr_data[0];
            CSR_CURSOR_X:    cursor_x_in    = csr_data[9:0];
            CSR_CURSOR_Y:    cursor_y_in    = csr_data[9:0];
            default: begin
               // unused index, write is dropped
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // handshake: result register frees up when empty or being taken,
   // input register frees up when empty or moving into the result register
   // ---------------------------------------------------------------------------
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !out_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_data_in  = s1_data_ff;
      if (!s1_valid_ff || out_ready) begin
         s1_valid_in = req_valid;
         s1_data_in  = req_data;
      end
   end

   // ---------------------------------------------------------------------------
   // compose, one pass over all layers
   // ---------------------------------------------------------------------------
   always_comb begin
      px = {4'b0000, s1_data_ff.pixel_x};
      py = {4'b0000, s1_data_ff.pixel_y};
      wx = {{2{win_x_ff[11]}}, win_x_ff};
      wy = {{2{win_y_ff[11]}}, win_y_ff};
      ww = {2'b00, win_width_ff};
      wh = {2'b00, win_height_ff};
      cx = {4'b0000, cursor_x_ff};
      cy = {4'b0000, cursor_y_ff};

      on_screen = (px < coord_type'(SCREEN_WIDTH)) && (py < coord_type'(SCREEN_HEIGHT));

      // 0x30 / 768 is exactly 1/16, so the gradient step is the row over 16
      grad_blue = GRAD_BLUE_BASE + {2'b00, s1_data_ff.pixel_y[9:4]};

      // sprite offsets, only the low four bits matter inside the sprite
      cur_dx = s1_data_ff.pixel_x - cursor_x_ff;
      cur_dy = s1_data_ff.pixel_y - cursor_y_ff;

      color = {GRAD_ALPHA, GRAD_RED, GRAD_GREEN, grad_blue};
      layer = LAYER_GRADIENT;

      if (on_screen) begin
         if (covers(px, py, PANEL_X, PANEL_Y, PANEL_W, PANEL_H)) begin
            color = COLOR_PANEL;
            layer = LAYER_PANEL;
         end
         if (covers(px, py, TEXT_X, TEXT_Y, TEXT_W, TEXT_H)) begin
            color = COLOR_TEXTBOX;
            layer = LAYER_TEXTBOX;
         end
         if (win_present_ff) begin
            // shadow is painted opaque with its own alpha, not blended
            if (covers(px, py, wx + SHADOW_OFS, wy + SHADOW_OFS, ww, wh)) begin
               color = COLOR_SHADOW;
               layer = LAYER_SHADOW;
            end
            if (covers(px, py, wx, wy - TITLE_H, ww, TITLE_H)) begin
               color = COLOR_TITLE;
               layer = LAYER_TITLE;
            end
            if (covers(px, py, wx + CLOSE_DX, wy - CLOSE_DY, CLOSE_SIZE, CLOSE_SIZE)) begin
               color = COLOR_CLOSE;
               layer = LAYER_CLOSE;
            end
            if (covers(px, py, wx, wy, ww, wh)) begin
               color = s1_data_ff.client_pixel;
               layer = LAYER_CLIENT;
            end
         end
         // cursor on top, transparent where the sprite code is zero
         if (covers(px, py, cx, cy, CURSOR_SZ, CURSOR_SZ)) begin
            if (SPRITE_WHITE[cur_dy[3:0]][cur_dx[3:0]]) begin
               color = COLOR_WHITE;
               layer = LAYER_CURSOR;
            end else if (SPRITE_BLUE[cur_dy[3:0]][cur_dx[3:0]]) begin
               color = COLOR_BLUE;
               layer = LAYER_CURSOR;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_ready) begin
         rsp_valid_in = s1_valid_ff;
         if (s1_valid_ff) begin
            rsp_data_in.pixel_color = color;
            rsp_data_in.layer       = layer;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         win_x_ff       <= '0;
         win_y_ff       <= '0;
         win_width_ff   <= '0;
         win_height_ff  <= '0;
         win_present_ff <= 1'b0;
         cursor_x_ff    <= CURSOR_X_RESET;
         cursor_y_ff    <= CURSOR_Y_RESET;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         win_x_ff       <= win_x_in;
         win_y_ff       <= win_y_in;
         win_width_ff   <= win_width_in;
         win_height_ff  <= win_height_in;
         win_present_ff <= win_present_in;
         cursor_x_ff    <= cursor_x_in;
         cursor_y_ff    <= cursor_y_in;
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      s1_data_ff  <= s1_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### hw/rtl/lpc_checker.sv
`include "layered_pixel_compositor_macros.svh"

module lpc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input lpc_pkg::rsp_type rsp_data
);

   // pixels accepted but not yet delivered
   logic [1:0] inflight_ff, inflight_in;
   logic       req_xfer, rsp_xfer;

   assign req_xfer = req_valid && !req_stall;
   assign rsp_xfer = rsp_valid && !rsp_stall;

   always_comb begin
      inflight_in = inflight_ff;
      if (req_xfer && !rsp_xfer) begin
         inflight_in = inflight_ff + 2'd1;
      end else if (rsp_xfer && !req_xfer) begin
         inflight_in = inflight_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   // stalled result holds
   `LPC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result changed")
   // input side never backs up while the result register is empty
   `LPC_ASSERT(a_no_false_stall, !rsp_valid |-> !req_stall, "input stalled with empty output")
   // no result without an accepted pixel behind it
   `LPC_ASSERT(a_no_phantom, rsp_valid |-> (inflight_ff != 2'd0), "result with nothing in flight")
   // two registers hold at most two pixels
   `LPC_ASSERT(a_capacity, inflight_ff != 2'd3, "more than two pixels in flight")

endmodule

bind layered_pixel_compositor lpc_checker u_lpc_checker (.*);
